// ----- hdl/stt_pkg.sv -----
// Package for the script text tokenizer.
// Holds the result record, the accumulator used while one byte is decoded,
// character and code constants, and the pure helper functions.
package stt_pkg;

    localparam int MAX_TOKEN = 1024;
    localparam int ROOM_CAP_I = (MAX_TOKEN - 1 < 1023) ? MAX_TOKEN - 1 : 1023;
    localparam logic [9:0] ROOM_CAP = ROOM_CAP_I[9:0];

    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_BRACKETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_COLON = 2'd2;
    localparam logic [CFG_W-1:0] TOKEN_SIZE_RST = 11'd1024;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_EOD = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [9:0] len;
        logic       quoted;
        logic       ovf;
        logic       last;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         n;
        logic [9:0]         cc;
        logic               ov;
    } t_acc;

    function automatic logic [9:0] room_of(logic [CFG_W-1:0] size);
        logic [CFG_W-1:0] lim;
        lim = (size < 11'd2) ? '0 : size - 11'd1;
        if (lim > {1'b0, ROOM_CAP}) begin
            lim = {1'b0, ROOM_CAP};
        end
        return lim[9:0];
    endfunction

    function automatic logic is_single(logic [7:0] c, logic ign_br, logic colon);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_APOS) || (c == CH_COMMA)
            || (!ign_br && ((c == CH_LPAREN) || (c == CH_RPAREN)))
            || (colon && (c == CH_COLON));
    endfunction

    function automatic t_acc acc_emit(t_acc a, logic [1:0] kind, logic [7:0] ch,
                                      logic [9:0] len, logic quoted, logic ovf);
        t_acc o;
        o = a;
        o.res[a.n[1:0]] = '{kind: kind, ch: ch, len: len, quoted: quoted, ovf: ovf,
                             last: 1'b0};
        o.n = a.n + 3'd1;
        return o;
    endfunction

    function automatic t_acc acc_begin(t_acc a);
        t_acc o;
        o = a;
        o.cc = '0;
        o.ov = 1'b0;
        return o;
    endfunction

    function automatic t_acc acc_store(t_acc a, logic [7:0] c, logic [9:0] room);
        t_acc o;
        o = a;
        if (a.cc < room) begin
            o = acc_emit(a, KIND_CHAR, c, '0, 1'b0, 1'b0);
            o.cc = a.cc + 10'd1;
        end else begin
            o.ov = 1'b1;
        end
        return o;
    endfunction

    function automatic t_acc acc_end(t_acc a, logic quoted);
        t_acc o;
        o = acc_emit(a, KIND_END, '0, a.cc, quoted, a.ov);
        return acc_begin(o);
    endfunction

    function automatic t_acc acc_eod(t_acc a);
        return acc_emit(a, KIND_EOD, '0, '0, 1'b0, 1'b0);
    endfunction

endpackage

// ----- hdl/script_text_tokenizer.sv -----
// Script text tokenizer, top level.
// Depends on stt_pkg for the result record, constants and helper functions.
//
// Usage:
// Text enters on the slave stream one byte per transfer in s_axis_tdata; a
// zero byte marks the end of the data. Tokens leave on the master stream one
// transfer per result: tuser gives the kind (character, token end, end of
// data), tdata the character or the length and flags of a finished token, and
// tlast marks the last result caused by one input byte.
// Each byte is decoded in the cycle it is taken; its first result is registered
// in the output register, or in the burst buffer while the output is held. A byte
// that gives at most one result is taken every cycle while the output is free. A
// byte that gives up to four results (a token ending at a single-character token,
// or a held slash or backslash) leaves the rest in a four-entry burst buffer, and
// the input waits until it drains, one result per cycle while the output is free.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_wdata
// while the block is idle. Reset empties the output and burst buffer, puts
// the scanner back to skipping whitespace and loads token size 1024 with
// brackets and colons as plain settings off. When the receiver stalls the
// result holds in the output register and the burst buffer fills; the input
// then stops taking bytes.
module script_text_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,
    // [7:0] token_char, [17:8] token_length, [18] is_quoted, [19] overflowed, zero fill
    output logic [1:0]                     m_axis_tuser,  // [1:0] kind
    output logic                           m_axis_tlast,  // last_of_run
    input  logic                           i_cfg_we,
    input  logic [stt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stt_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_SLASH   = 3'd1,
        M_COMMENT = 3'd2,
        M_WORD    = 3'd3,
        M_QUOTE   = 3'd4,
        M_QBSL    = 3'd5
    } t_mode;

    typedef struct packed {
        t_acc  acc;
        t_mode mode;
    } t_step;

    t_mode               r_mode, n_mode;
    logic [9:0]          r_cc;
    logic                r_ov;
    logic [9:0]          r_room;
    logic                r_ign_br;
    logic                r_colon;
    t_res [MAX_RES-1:0]  r_buf;
    logic [1:0]          r_ptr;
    logic [2:0]          r_left;
    t_res                r_out;
    logic                r_out_valid;
    t_acc                n_acc;
    logic                accept;
    logic                out_free;

    function automatic t_step word_step(t_step s, logic [7:0] b, logic [9:0] room,
                                        logic ign_br, logic colon);
        t_step o;
        o = s;
        if (b == CH_NUL) begin
            o.acc = acc_eod(acc_end(s.acc, 1'b0));
            o.mode = M_IDLE;
        end else if (is_single(b, ign_br, colon)) begin
            o.acc = acc_end(acc_store(acc_begin(acc_end(s.acc, 1'b0)), b, room), 1'b0);
            o.mode = M_IDLE;
        end else if (b <= CH_SPACE) begin
            o.acc = acc_end(s.acc, 1'b0);
            o.mode = M_IDLE;
        end else begin
            o.acc = acc_store(s.acc, b, room);
        end
        return o;
    endfunction

    function automatic t_step quote_step(t_step s, logic [7:0] b, logic [9:0] room);
        t_step o;
        o = s;
        if (b == CH_NUL) begin
            o.acc = acc_eod(acc_end(s.acc, 1'b1));
            o.mode = M_IDLE;
        end else if (b == CH_BSLASH) begin
            o.mode = M_QBSL;
        end else if (b == CH_DQUOTE) begin
            o.acc = acc_end(s.acc, 1'b1);
            o.mode = M_IDLE;
        end else begin
            o.acc = acc_store(s.acc, b, room);
            o.mode = M_QUOTE;
        end
        return o;
    endfunction

    always_comb begin
        t_step      st;
        logic [7:0] b;
        logic [2:0] last_idx;
        b = s_axis_tdata;
        st.acc = '0;
        st.acc.cc = r_cc;
        st.acc.ov = r_ov;
        st.mode = r_mode;
        case (r_mode)
            M_SLASH: begin
                if (b == CH_SLASH) begin
                    st.mode = M_COMMENT;
                end else begin
                    st.acc = acc_store(acc_begin(st.acc), CH_SLASH, r_room);
                    st.mode = M_WORD;
                    st = word_step(st, b, r_room, r_ign_br, r_colon);
                end
            end
            M_COMMENT: begin
                if (b == CH_NUL) begin
                    st.acc = acc_eod(st.acc);
                    st.mode = M_IDLE;
                end else if (b == CH_NEWLINE) begin
                    st.mode = M_IDLE;
                end
            end
            M_WORD: begin
                st = word_step(st, b, r_room, r_ign_br, r_colon);
            end
            M_QUOTE: begin
                st = quote_step(st, b, r_room);
            end
            M_QBSL: begin
                if (b == CH_DQUOTE) begin
                    st.acc = acc_store(st.acc, CH_DQUOTE, r_room);
                    st.mode = M_QUOTE;
                end else begin
                    st.acc = acc_store(st.acc, CH_BSLASH, r_room);
                    st = quote_step(st, b, r_room);
                end
            end
            default: begin
                st.mode = M_IDLE;
                if (b == CH_NUL) begin
                    st.acc = acc_eod(st.acc);
                end else if (b <= CH_SPACE) begin
                    st.mode = M_IDLE;
                end else if (b == CH_SLASH) begin
                    st.mode = M_SLASH;
                end else if (b == CH_DQUOTE) begin
                    st.acc = acc_begin(st.acc);
                    st.mode = M_QUOTE;
                end else if (is_single(b, r_ign_br, r_colon)) begin
                    st.acc = acc_end(acc_store(acc_begin(st.acc), b, r_room), 1'b0);
                end else begin
                    st.acc = acc_store(acc_begin(st.acc), b, r_room);
                    st.mode = M_WORD;
                end
            end
        endcase
        last_idx = st.acc.n - 3'd1;
        if (st.acc.n != 3'd0) begin
            st.acc.res[last_idx[1:0]].last = 1'b1;
        end
        n_acc = st.acc;
        n_mode = st.mode;
    end

    assign s_axis_tready = (r_left == 3'd0);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cc <= '0;
            r_ov <= 1'b0;
            r_room <= room_of(TOKEN_SIZE_RST);
            r_ign_br <= 1'b0;
            r_colon <= 1'b0;
            r_ptr <= '0;
            r_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOKEN_SIZE:      r_room <= room_of(i_cfg_wdata);
                    CFG_IGNORE_BRACKETS: r_ign_br <= i_cfg_wdata[0];
                    CFG_HANDLE_COLON:    r_colon <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_mode <= n_mode;
                r_cc <= n_acc.cc;
                r_ov <= n_acc.ov;
            end
            if (out_free) begin
                if (r_left != 3'd0) begin
                    r_out_valid <= 1'b1;
                    r_ptr <= r_ptr + 2'd1;
                    r_left <= r_left - 3'd1;
                end else if (accept && (n_acc.n != 3'd0)) begin
                    r_out_valid <= 1'b1;
                    r_ptr <= 2'd1;
                    r_left <= n_acc.n - 3'd1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept) begin
                r_ptr <= 2'd0;
                r_left <= n_acc.n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_acc.res;
        end
        if (out_free) begin
            if (r_left != 3'd0) begin
                r_out <= r_buf[r_ptr];
            end else if (accept) begin
                r_out <= n_acc.res[0];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {4'd0, r_out.ovf, r_out.quoted, r_out.len, r_out.ch};
    assign m_axis_tuser = r_out.kind;
    assign m_axis_tlast = r_out.last;

endmodule

// ----- test/script_text_tokenizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for script_text_tokenizer: random and directed text streams,
// a token predictor kept in step with the block, and randomized stream back-pressure.
// Depends on stt_pkg for the result record, character codes and register indexes.
module script_text_tokenizer_test;
    import stt_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_SLASH, SCAN_COMMENT, SCAN_WORD, SCAN_QUOTE, SCAN_QUOTE_ESC
    } t_scan_mode;

    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;   // [7:0] text_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] token_char, [17:8] token_length, [18] is_quoted, [19] overflowed
    logic [23:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;        // [1:0] kind
    logic                 m_axis_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic [7:0] text_q[$];
    t_res       token_q[$];
    t_res       byte_out[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         rx_hold_req = 1'b0;
    int         rx_hold_count = 0;
    int         fault_count = 0;

    t_scan_mode scan = SCAN_IDLE;
    logic [9:0] tok_len = '0;
    logic       tok_dropped = 1'b0;
    logic [10:0] size_reg = TOKEN_SIZE_RST;
    logic       ign_br_reg = 1'b0;
    logic       colon_reg = 1'b0;

    script_text_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Token predictor.
    function automatic logic [9:0] char_room();
        int lim;
        lim = (size_reg < 11'd2) ? 0 : int'(size_reg) - 1;
        if (lim > MAX_TOKEN - 1) lim = MAX_TOKEN - 1;
        if (lim > 1023) lim = 1023;
        return 10'(lim);
    endfunction

    function automatic bit splits_word(logic [7:0] c);
        case (c)
            CH_LBRACE, CH_RBRACE, CH_APOS, CH_COMMA: return 1'b1;
            CH_LPAREN, CH_RPAREN: return !ign_br_reg;
            CH_COLON: return colon_reg;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void add_out(logic [1:0] k, logic [7:0] c, logic [9:0] n,
                                    logic q, logic ov);
        t_res r;
        r.kind = k;
        r.ch = c;
        r.len = n;
        r.quoted = q;
        r.ovf = ov;
        r.last = 1'b0;
        byte_out.push_back(r);
    endfunction

    function automatic void keep_char(logic [7:0] c);
        if (tok_len < char_room()) begin
            add_out(KIND_CHAR, c, '0, 1'b0, 1'b0);
            tok_len = tok_len + 10'd1;
        end else begin
            tok_dropped = 1'b1;
        end
    endfunction

    function automatic void close_token(logic q);
        add_out(KIND_END, '0, tok_len, q, tok_dropped);
        tok_len = '0;
        tok_dropped = 1'b0;
    endfunction

    function automatic void punct_token(logic [7:0] c);
        tok_len = '0;
        tok_dropped = 1'b0;
        keep_char(c);
        close_token(1'b0);
    endfunction

    function automatic void word_step(logic [7:0] b);
        if (b == CH_NUL) begin
            close_token(1'b0);
            add_out(KIND_EOD, '0, '0, 1'b0, 1'b0);
            scan = SCAN_IDLE;
        end else if (splits_word(b)) begin
            close_token(1'b0);
            punct_token(b);
            scan = SCAN_IDLE;
        end else if (b <= CH_SPACE) begin
            close_token(1'b0);
            scan = SCAN_IDLE;
        end else begin
            keep_char(b);
        end
    endfunction

    function automatic void quote_step(logic [7:0] b);
        if (b == CH_NUL) begin
            close_token(1'b1);
            add_out(KIND_EOD, '0, '0, 1'b0, 1'b0);
            scan = SCAN_IDLE;
        end else if (b == CH_BSLASH) begin
            scan = SCAN_QUOTE_ESC;
        end else if (b == CH_DQUOTE) begin
            close_token(1'b1);
            scan = SCAN_IDLE;
        end else begin
            keep_char(b);
            scan = SCAN_QUOTE;
        end
    endfunction

    function automatic void idle_step(logic [7:0] b);
        scan = SCAN_IDLE;
        if (b == CH_NUL) begin
            add_out(KIND_EOD, '0, '0, 1'b0, 1'b0);
        end else if (b <= CH_SPACE) begin
            scan = SCAN_IDLE;
        end else if (b == CH_SLASH) begin
            scan = SCAN_SLASH;
        end else if (b == CH_DQUOTE) begin
            tok_len = '0;
            tok_dropped = 1'b0;
            scan = SCAN_QUOTE;
        end else if (splits_word(b)) begin
            punct_token(b);
        end else begin
            tok_len = '0;
            tok_dropped = 1'b0;
            keep_char(b);
            scan = SCAN_WORD;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        t_res r;
        byte_out.delete();
        case (scan)
            SCAN_SLASH: begin
                if (b == CH_SLASH) begin
                    scan = SCAN_COMMENT;
                end else begin
                    tok_len = '0;
                    tok_dropped = 1'b0;
                    keep_char(CH_SLASH);
                    scan = SCAN_WORD;
                    word_step(b);
                end
            end
            SCAN_COMMENT: begin
                if (b == CH_NUL) begin
                    add_out(KIND_EOD, '0, '0, 1'b0, 1'b0);
                    scan = SCAN_IDLE;
                end else if (b == CH_NEWLINE) begin
                    scan = SCAN_IDLE;
                end
            end
            SCAN_WORD: word_step(b);
            SCAN_QUOTE: quote_step(b);
            SCAN_QUOTE_ESC: begin
                if (b == CH_DQUOTE) begin
                    keep_char(CH_DQUOTE);
                    scan = SCAN_QUOTE;
                end else begin
                    keep_char(CH_BSLASH);
                    quote_step(b);
                end
            end
            default: idle_step(b);
        endcase
        for (int i = 0; i < byte_out.size(); i++) begin
            r = byte_out[i];
            r.last = (i == byte_out.size() - 1);
            token_q.push_back(r);
        end
    endfunction

    function automatic void check_result();
        t_res got;
        t_res want;
        got.kind = m_axis_tuser;
        got.ch = m_axis_tdata[7:0];
        got.len = m_axis_tdata[17:8];
        got.quoted = m_axis_tdata[18];
        got.ovf = m_axis_tdata[19];
        got.last = m_axis_tlast;
        if (token_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("unexpected result: kind %0d char %02h len %0d q %0d ov %0d last %0d",
                         got.kind, got.ch, got.len, got.quoted, got.ovf, got.last);
        end else begin
            want = token_q.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.len !== want.len
                    || got.quoted !== want.quoted || got.ovf !== want.ovf
                    || got.last !== want.last) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("mismatch: expected kind %0d char %02h len %0d q %0d ov %0d last %0d",
                             want.kind, want.ch, want.len, want.quoted, want.ovf, want.last);
                    $display("          actual kind %0d char %02h len %0d q %0d ov %0d last %0d",
                             got.kind, got.ch, got.len, got.quoted, got.ovf, got.last);
                end
            end
        end
    endfunction

    // Sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= text_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_req && rx_hold_count < RX_HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every input transfer, checks every output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) check_result();
        end
    end

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255, 33));
        end while (c == CH_LBRACE || c == CH_RBRACE || c == CH_APOS || c == CH_COMMA
                   || c == CH_LPAREN || c == CH_RPAREN || c == CH_COLON);
        return c;
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(6))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_APOS;
            3: return CH_COMMA;
            4: return CH_LPAREN;
            5: return CH_RPAREN;
            default: return CH_COLON;
        endcase
    endfunction

    // Mostly well-formed tokens with random content, plus stray bytes and broken pieces.
    task automatic add_text(int target);
        logic [7:0] txt[$];
        logic [7:0] c;
        int sel;
        int n;
        while (txt.size() < target) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
                repeat (n) txt.push_back(word_char());
            end else if (sel < 40) begin
                txt.push_back(punct_char());
            end else if (sel < 55) begin
                txt.push_back(CH_DQUOTE);
                n = $urandom_range(6);
                repeat (n) begin
                    case ($urandom_range(9))
                        0: begin
                            txt.push_back(CH_BSLASH);
                            txt.push_back(CH_DQUOTE);
                        end
                        1: txt.push_back(CH_BSLASH);
                        default: begin
                            do c = 8'($urandom_range(255, 1)); while (c == CH_DQUOTE);
                            txt.push_back(c);
                        end
                    endcase
                end
                txt.push_back(($urandom_range(9) == 0) ? CH_NUL : CH_DQUOTE);
            end else if (sel < 65) begin
                txt.push_back(CH_SLASH);
                txt.push_back(CH_SLASH);
                n = $urandom_range(5);
                repeat (n) begin
                    do c = 8'($urandom_range(255, 1)); while (c == CH_NEWLINE);
                    txt.push_back(c);
                end
                txt.push_back(($urandom_range(9) == 0) ? CH_NUL : CH_NEWLINE);
            end else if (sel < 73) begin
                txt.push_back(CH_SLASH);
                n = $urandom_range(4);
                repeat (n) txt.push_back(word_char());
            end else if (sel < 80) begin
                txt.push_back(CH_NUL);
            end else if (sel < 90) begin
                n = $urandom_range(3, 1);
                repeat (n) txt.push_back(8'($urandom_range(32, 1)));
            end else begin
                txt.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(1) == 0) txt.push_back(8'($urandom_range(32, 1)));
        end
        foreach (txt[i]) text_q.push_back(txt[i]);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TOKEN_SIZE: size_reg = val;
            CFG_IGNORE_BRACKETS: ign_br_reg = val[0];
            CFG_HANDLE_COLON: colon_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (text_q.size() != 0 || s_axis_tvalid || token_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] size, logic ib, logic hc);
        write_reg(CFG_TOKEN_SIZE, size);
        write_reg(CFG_IGNORE_BRACKETS, {10'd0, ib});
        write_reg(CFG_HANDLE_COLON, {10'd0, hc});
    endtask

    task automatic run_phase(logic [CFG_W-1:0] size, logic ib, logic hc,
                             int send_pct, int recv_pct, int n_items);
        set_regs(size, ib, hc);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        add_text(n_items);
        text_q.push_back(CH_NUL);
        settle();
    endtask

    initial begin
        logic [7:0] directed_text[$] = '{
            CH_SPACE, 8'h01, CH_LBRACE, CH_RBRACE, CH_APOS, CH_COMMA, CH_LPAREN, CH_RPAREN,
            CH_COLON, 8'hFF, CH_COMMA, CH_SLASH, CH_LBRACE, CH_DQUOTE, CH_BSLASH, CH_DQUOTE,
            CH_BSLASH, CH_BSLASH, CH_DQUOTE, CH_DQUOTE, CH_SLASH, CH_SLASH, CH_NEWLINE,
            8'h77, CH_NUL};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every kind of token, escapes, a comment and a held slash.
        foreach (directed_text[i]) text_q.push_back(directed_text[i]);
        settle();

        run_phase(11'd8, 1'b1, 1'b1, 80, 0, 12);
        run_phase(11'd2, 1'b0, 1'b1, 0, 80, 12);
        run_phase(11'd1, 1'b1, 1'b0, 19, 19, 12);

        // Largest size: a long word while the receiver holds off for a long stretch so
        // the block backs up; then the sender waits for the output to drain.
        set_regs(11'd2047, 1'b0, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rx_hold_req = 1'b1;
        repeat (10) text_q.push_back(word_char());
        text_q.push_back(CH_SPACE);
        add_text(5);
        settle();
        add_text(5);
        text_q.push_back(CH_NUL);
        settle();

        run_phase(11'd0, 1'b1, 1'b1, 19, 19, 4);
        run_phase(11'd1024, 1'b0, 1'b0, 0, 0, 4);

        if (fault_count == 0) begin
            $display("script_text_tokenizer verification clean");
        end else begin
            $display("script_text_tokenizer verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("script_text_tokenizer verification failed");
        $finish;
    end
endmodule
